// File: hw/rtl/naat_pkg.sv
// Package for the network address allocation table.
// Holds table dimensions, derived widths and operation codes; no dependencies.
package naat_pkg;

  localparam int ROUTER_ROWS   = 16;
  localparam int SLOTS_PER_ROW = 16;
  localparam int TABLE_SLOTS   = ROUTER_ROWS * SLOTS_PER_ROW;

  localparam int ROW_W  = (ROUTER_ROWS > 1) ? $clog2(ROUTER_ROWS) : 1;
  localparam int SLOT_W = $clog2(SLOTS_PER_ROW);
  localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int LEFT_W = $clog2(TABLE_SLOTS + 1);

  localparam logic [15:0] EMPTY_ADDR  = 16'hFFFF;
  localparam logic [7:0]  ROUTER_LSB  = 8'h01;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_LONG   = 3'd2;
  localparam logic [2:0] OP_JOIN   = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

endpackage

// File: hw/rtl/network_address_allocation_table.sv
// Network address allocation table: router rows of tag slots, one id memory.
// Depends on naat_pkg (dimensions, widths, operation codes).
//
// One request word in, one result word out. The table has ROUTER_ROWS rows of
// SLOTS_PER_ROW slots; slot 0 of a row is the router (address row<<8 | 1),
// slot j a tag under it (address (row<<8)+j+1). A slot's short address follows
// from its position, so only the 64-bit node ids live in a single-port-read
// memory; one valid flop per slot marks occupancy and reset empties the whole
// table at once (no clearing pass). Each request is handled by a small
// sequencer that walks candidate slots through one shared comparator, one
// slot per cycle, with the id read registered in front of the compare. A
// request visits up to SLOTS_PER_ROW slots before a hit for row work
// (tag add, delete, long lookup, tag join), up to ROUTER_ROWS for router add
// and router join, and up to ROUTER_ROWS*SLOTS_PER_ROW (256) for a search by
// node id. in_ready is high only while the block is idle; a finished result
// holds on the out_ port until taken. Failed requests return success 0,
// address 0xFFFF and id 0; a delete whose row byte is out of range fails.
module network_address_allocation_table import naat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic        in_device_is_tag,
  input  logic [15:0] in_father_addr,
  input  logic [63:0] in_node_id,
  input  logic [15:0] in_short_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_success,
  output logic [15:0] out_short_addr_out,
  output logic [63:0] out_node_id_out
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_WALK, S_DONE} state_t;
  typedef enum logic [1:0] {W_ROW, W_ROUTERS, W_ALL} walk_t;
  typedef enum logic [1:0] {C_FREE, C_ADDR, C_ID} cond_t;

  state_t state_r, state_nxt;

  // latched request word
  logic [2:0]  op_r, op_nxt;
  logic        tag_r, tag_nxt;
  logic [15:0] father_r, father_nxt;
  logic [63:0] id_r, id_nxt;
  logic [15:0] saddr_r, saddr_nxt;

  // walk control: issue side
  walk_t              walk_r, walk_nxt;
  cond_t              cond_r, cond_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;

  // walk control: compare side (registered alongside the memory read data)
  logic               cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [ROW_W-1:0]   cmp_row_r, cmp_row_nxt;
  logic [SLOT_W-1:0]  cmp_slot_r, cmp_slot_nxt;

  // result word
  logic        success_r, success_nxt;
  logic [15:0] sout_r, sout_nxt;
  logic [63:0] idout_r, idout_nxt;

  // occupancy and id store
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [63:0]            id_mem [TABLE_SLOTS];
  logic [63:0]            rd_data_r;
  logic                   wr_en;

  // setup decode
  logic [7:0]       sel_row8;
  logic             row_in_range;
  logic [IDX_W-1:0] base_idx;
  logic             router_live;
  logic             father_ok;

  // shared compare unit
  logic [15:0] cmp_addr;
  logic        cmp_used;
  logic        hit;

  assign sel_row8     = (op_r inside {OP_DELETE, OP_LONG}) ? saddr_r[15:8] : father_r[15:8];
  assign row_in_range = sel_row8 < 8'(ROUTER_ROWS);
  assign base_idx     = IDX_W'(32'(sel_row8) * SLOTS_PER_ROW);
  assign router_live  = row_in_range && valid_r[base_idx];
  assign father_ok    = router_live && (father_r[7:0] == ROUTER_LSB);

  assign cmp_addr = (16'(cmp_row_r) << 8) + 16'(cmp_slot_r) + 16'd1;
  assign cmp_used = valid_r[cmp_idx_r];

  always_comb begin
    hit = 1'b0;
    if (cmp_v_r) begin
      case (cond_r)
        C_FREE:  hit = !cmp_used;
        C_ADDR:  hit = cmp_used && (cmp_addr == saddr_r);
        C_ID:    hit = cmp_used && (rd_data_r == id_r);
        default: hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    tag_nxt      = tag_r;
    father_nxt   = father_r;
    id_nxt       = id_r;
    saddr_nxt    = saddr_r;
    walk_nxt     = walk_r;
    cond_nxt     = cond_r;
    idx_nxt      = idx_r;
    row_nxt      = row_r;
    slot_nxt     = slot_r;
    left_nxt     = left_r;
    cmp_v_nxt    = 1'b0;
    cmp_idx_nxt  = idx_r;
    cmp_row_nxt  = row_r;
    cmp_slot_nxt = slot_r;
    success_nxt  = success_r;
    sout_nxt     = sout_r;
    idout_nxt    = idout_r;
    valid_nxt    = valid_r;
    wr_en        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          tag_nxt    = in_device_is_tag;
          father_nxt = in_father_addr;
          id_nxt     = in_node_id;
          saddr_nxt  = in_short_addr;
          state_nxt  = S_SETUP;
        end
      end

      S_SETUP: begin
        // default: walk one row starting at the selected row's slot 0
        walk_nxt    = W_ROW;
        cond_nxt    = C_ID;
        idx_nxt     = base_idx;
        row_nxt     = ROW_W'(sel_row8);
        slot_nxt    = '0;
        left_nxt    = '0;
        success_nxt = 1'b0;
        sout_nxt    = EMPTY_ADDR;
        idout_nxt   = '0;
        case (op_r)
          OP_ADD: begin
            cond_nxt = C_FREE;
            if (!tag_r) begin
              walk_nxt = W_ROUTERS;
              idx_nxt  = '0;
              row_nxt  = '0;
              left_nxt = LEFT_W'(ROUTER_ROWS);
            end else if (father_ok) begin
              left_nxt = LEFT_W'(SLOTS_PER_ROW);
            end
          end
          OP_DELETE: begin
            cond_nxt = C_ADDR;
            if (row_in_range) left_nxt = LEFT_W'(SLOTS_PER_ROW);
          end
          OP_LONG: begin
            cond_nxt = C_ADDR;
            if (router_live) left_nxt = LEFT_W'(SLOTS_PER_ROW);
          end
          OP_JOIN: begin
            cond_nxt = C_ID;
            if (!tag_r) begin
              walk_nxt = W_ROUTERS;
              idx_nxt  = '0;
              row_nxt  = '0;
              left_nxt = LEFT_W'(ROUTER_ROWS);
            end else if (father_ok) begin
              left_nxt = LEFT_W'(SLOTS_PER_ROW);
            end
          end
          OP_FIND: begin
            cond_nxt = C_ID;
            walk_nxt = W_ALL;
            idx_nxt  = '0;
            row_nxt  = '0;
            left_nxt = LEFT_W'(TABLE_SLOTS);
          end
          default: left_nxt = '0;
        endcase
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (hit) begin
          success_nxt = 1'b1;
          state_nxt   = S_DONE;
          case (op_r)
            OP_ADD: begin
              wr_en                = 1'b1;
              valid_nxt[cmp_idx_r] = 1'b1;
              sout_nxt             = cmp_addr;
            end
            OP_DELETE: valid_nxt[cmp_idx_r] = 1'b0;
            OP_LONG:   idout_nxt = rd_data_r;
            default:   sout_nxt  = cmp_addr;
          endcase
        end else if (left_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cmp_v_nxt = 1'b1;
          left_nxt  = left_r - LEFT_W'(1);
          case (walk_r)
            W_ROUTERS: begin
              row_nxt = row_r + ROW_W'(1);
              idx_nxt = idx_r + IDX_W'(SLOTS_PER_ROW);
            end
            W_ALL: begin
              idx_nxt = idx_r + IDX_W'(1);
              if (slot_r == SLOT_W'(SLOTS_PER_ROW - 1)) begin
                slot_nxt = '0;
                row_nxt  = row_r + ROW_W'(1);
              end else begin
                slot_nxt = slot_r + SLOT_W'(1);
              end
            end
            default: begin
              idx_nxt  = idx_r + IDX_W'(1);
              slot_nxt = slot_r + SLOT_W'(1);
            end
          endcase
        end
      end

      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmp_v_r <= 1'b0;
      valid_r <= '0;
      walk_r  <= W_ROW;
      cond_r  <= C_FREE;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= cmp_v_nxt;
      valid_r <= valid_nxt;
      walk_r  <= walk_nxt;
      cond_r  <= cond_nxt;
      left_r  <= left_nxt;
    end
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    father_r   <= father_nxt;
    id_r       <= id_nxt;
    saddr_r    <= saddr_nxt;
    idx_r      <= idx_nxt;
    row_r      <= row_nxt;
    slot_r     <= slot_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_row_r  <= cmp_row_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    success_r  <= success_nxt;
    sout_r     <= sout_nxt;
    idout_r    <= idout_nxt;
  end

  // id memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) id_mem[cmp_idx_r] <= id_r;
    rd_data_r <= id_mem[idx_r];
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_success        = success_r;
  assign out_short_addr_out = sout_r;
  assign out_node_id_out    = idout_r;

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result word is pending");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_success) |-> (out_short_addr_out == EMPTY_ADDR && out_node_id_out == '0))
    else $error("failed request returned a non-empty result");

  a_id_only_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_node_id_out != '0) |-> (op_r == OP_LONG && out_success))
    else $error("node id returned by an operation other than long lookup");

  a_one_slot_change: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 ($countones(valid_r ^ $past(valid_r)) <= 1))
    else $error("more than one slot changed in one cycle");

  a_walk_only: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r != $past(valid_r)) |-> ($past(state_r) == S_WALK && $past(hit)))
    else $error("table changed outside a walk hit");

endmodule

// File: sim/tb_network_address_allocation_table.sv
// Self-checking testbench for network_address_allocation_table.
// Drives request words from a directed table and then random traffic, and checks
// every result word against a typed answer or a built-in table predictor. Depends on naat_pkg.
module tb_network_address_allocation_table;
  import naat_pkg::*;

  // Unused operation codes; the block must answer them with a failed result.
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic [63:0] ID_ALL_ONES = '1;

  localparam int RANDOM_WORDS  = 1500;
  // No idling on either side while this many words have been sent.
  localparam int STEADY_FROM   = 700;
  localparam int STEADY_TO     = 1000;
  // Receiver back-pressure: one long hold with the sender still offering.
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 600;
  // A full id search walks 256 slots; leave room for that after the last word.
  localparam int DRAIN_CYCLES  = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;

  typedef struct packed {
    logic [2:0]  op;
    logic        tag;
    logic [15:0] father;
    logic [63:0] id;
    logic [15:0] saddr;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] sa;
    logic [63:0] id;
  } outcome_t;

  typedef struct {
    request_t rq;
    bit       typed;   // want holds a hand-written answer
    outcome_t want;
  } directed_row_t;

  localparam outcome_t NO_HIT = {1'b0, EMPTY_ADDR, 64'd0};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_operation;
  logic        in_device_is_tag;
  logic [15:0] in_father_addr;
  logic [63:0] in_node_id;
  logic [15:0] in_short_addr;
  logic        out_valid;
  logic        out_ready;
  logic        out_success;
  logic [15:0] out_short_addr_out;
  logic [63:0] out_node_id_out;

  network_address_allocation_table u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_device_is_tag   (in_device_is_tag),
    .in_father_addr     (in_father_addr),
    .in_node_id         (in_node_id),
    .in_short_addr      (in_short_addr),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_success        (out_success),
    .out_short_addr_out (out_short_addr_out),
    .out_node_id_out    (out_node_id_out)
  );

  // Shadow of the allocation table. A slot is free when its address is the
  // empty marker; ids of free slots are all ones, as at the start of the run.
  logic [15:0] slot_addr [TABLE_SLOTS];
  logic [63:0] slot_id   [TABLE_SLOTS];

  outcome_t      pending_results [$];
  directed_row_t directed_rows [$];
  logic [63:0]   id_pool [8];

  int          words_sent;
  int          results_seen;
  int          mismatches;
  int          hold_left;
  bit          hold_done;
  int unsigned cycles_run;

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run if results stop coming; nothing runs after it fires.
  initial begin
    for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge clk);
    $display("network_address_allocation_table: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------
  function automatic bit occupied(int idx);
    return slot_addr[idx] != EMPTY_ADDR;
  endfunction

  // Row whose router slot holds addr, -1 when no router has it.
  function automatic int router_row(logic [15:0] addr);
    for (int r = 0; r < ROUTER_ROWS; r++)
      if (occupied(r * SLOTS_PER_ROW) && slot_addr[r * SLOTS_PER_ROW] == addr) return r;
    return -1;
  endfunction

  function automatic void claim_slot(int idx, logic [15:0] addr, logic [63:0] id);
    slot_addr[idx] = addr;
    slot_id[idx]   = id;
  endfunction

  // Applies one request to the shadow table and returns the result word it
  // should produce. Every hit sets ok, which also stops the search loops.
  function automatic outcome_t allocate_step(request_t rq);
    outcome_t res;
    int       r;
    int       idx;
    res = NO_HIT;
    case (rq.op)
      OP_ADD: begin
        if (!rq.tag) begin
          // router: first row with a free router slot
          for (r = 0; r < ROUTER_ROWS && !res.ok; r++) begin
            idx = r * SLOTS_PER_ROW;
            if (!occupied(idx)) begin
              claim_slot(idx, 16'((r << 8) | ROUTER_LSB), rq.id);
              res.ok = 1'b1;
              res.sa = slot_addr[idx];
            end
          end
        end else begin
          // tag: first free slot in the father's row
          r = router_row(rq.father);
          if (r >= 0) begin
            for (int j = 0; j < SLOTS_PER_ROW && !res.ok; j++) begin
              idx = r * SLOTS_PER_ROW + j;
              if (!occupied(idx)) begin
                claim_slot(idx, 16'((r << 8) + j + 1), rq.id);
                res.ok = 1'b1;
                res.sa = slot_addr[idx];
              end
            end
          end
        end
      end
      OP_DELETE: begin
        // row straight from the high byte; out-of-range rows just fail
        r = int'(rq.saddr[15:8]);
        if (r < ROUTER_ROWS) begin
          for (int j = 0; j < SLOTS_PER_ROW && !res.ok; j++) begin
            idx = r * SLOTS_PER_ROW + j;
            if (occupied(idx) && slot_addr[idx] == rq.saddr) begin
              claim_slot(idx, EMPTY_ADDR, ID_ALL_ONES);
              res.ok = 1'b1;
            end
          end
        end
      end
      OP_LONG: begin
        r = router_row({rq.saddr[15:8], ROUTER_LSB});
        if (r >= 0) begin
          for (int j = 0; j < SLOTS_PER_ROW && !res.ok; j++) begin
            idx = r * SLOTS_PER_ROW + j;
            if (occupied(idx) && slot_addr[idx] == rq.saddr) begin
              res.ok = 1'b1;
              res.id = slot_id[idx];
            end
          end
        end
      end
      OP_JOIN: begin
        if (rq.tag) begin
          r = router_row(rq.father);
          if (r >= 0) begin
            for (int j = 0; j < SLOTS_PER_ROW && !res.ok; j++) begin
              idx = r * SLOTS_PER_ROW + j;
              if (occupied(idx) && slot_id[idx] == rq.id) begin
                res.ok = 1'b1;
                res.sa = slot_addr[idx];
              end
            end
          end
        end else begin
          for (r = 0; r < ROUTER_ROWS && !res.ok; r++) begin
            idx = r * SLOTS_PER_ROW;
            if (occupied(idx) && slot_id[idx] == rq.id) begin
              res.ok = 1'b1;
              res.sa = slot_addr[idx];
            end
          end
        end
      end
      OP_FIND: begin
        // row-major walk over the whole table, free slots skipped
        for (idx = 0; idx < TABLE_SLOTS && !res.ok; idx++) begin
          if (occupied(idx) && slot_id[idx] == rq.id) begin
            res.ok = 1'b1;
            res.sa = slot_addr[idx];
          end
        end
      end
      default: ;  // spare codes: nothing changes, failed result
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random request generation, steered by the shadow table
  // ---------------------------------------------------------------------------
  function automatic bit steady_window();
    return words_sent >= STEADY_FROM && words_sent < STEADY_TO;
  endfunction

  // Random occupied slot (router slots only if asked), -1 if there is none.
  function automatic int pick_live(bit routers_only);
    int count;
    int pick;
    count = 0;
    for (int k = 0; k < TABLE_SLOTS; k++)
      if (occupied(k) && (!routers_only || k % SLOTS_PER_ROW == 0)) count++;
    if (count == 0) return -1;
    pick = $urandom_range(count - 1);
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      if (occupied(k) && (!routers_only || k % SLOTS_PER_ROW == 0)) begin
        if (pick == 0) return k;
        pick--;
      end
    end
    return -1;
  endfunction

  // Pool ids repeat so that joins and searches hit duplicates.
  function automatic logic [63:0] random_id();
    if ($urandom_range(99) < 40) return id_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  // Address with a row byte in the table's row range and a low byte of 0 to SLOTS_PER_ROW, possibly never assigned.
  function automatic logic [15:0] in_range_addr();
    return 16'(($urandom_range(ROUTER_ROWS - 1) << 8) + $urandom_range(SLOTS_PER_ROW));
  endfunction

  function automatic request_t random_request(bit draining);
    request_t rq;
    int       roll;
    int       add_w;
    int       del_w;
    int       k;
    rq.op     = OP_ADD;
    rq.tag    = 1'($urandom_range(1));
    rq.father = 16'($urandom);
    rq.id     = random_id();
    rq.saddr  = 16'($urandom);
    // one word in ten is pure noise, any code and any field value
    if ($urandom_range(99) < 10) begin
      rq.op = 3'($urandom_range(7));
      rq.id = {$urandom, $urandom};
      return rq;
    end
    // alternate filling and draining so rows and the router column go full
    add_w = draining ? 20 : 45;
    del_w = draining ? 35 : 10;
    roll  = $urandom_range(99);
    if (roll < add_w) begin
      rq.op  = OP_ADD;
      rq.tag = ($urandom_range(99) >= 30);
      k = pick_live(1'b1);
      if (k >= 0 && $urandom_range(99) < 90) rq.father = slot_addr[k];
    end else if (roll < add_w + del_w) begin
      rq.op = OP_DELETE;
      k = pick_live(1'b0);
      rq.saddr = (k >= 0 && $urandom_range(99) < 85) ? slot_addr[k] : in_range_addr();
    end else if (roll < add_w + del_w + 15) begin
      rq.op = OP_LONG;
      k = pick_live(1'b0);
      rq.saddr = (k >= 0 && $urandom_range(99) < 80) ? slot_addr[k] : in_range_addr();
    end else if (roll < add_w + del_w + 30) begin
      rq.op = OP_JOIN;
      k = pick_live(1'b1);
      if (k >= 0) begin
        rq.father = slot_addr[k];
        // id of some slot in that row, or of the router itself
        if ($urandom_range(99) < 70)
          rq.id = rq.tag ? slot_id[k + $urandom_range(SLOTS_PER_ROW - 1)] : slot_id[k];
      end
    end else begin
      rq.op = OP_FIND;
      k = pick_live(1'b0);
      if (k >= 0 && $urandom_range(99) < 70) rq.id = slot_id[k];
      else if ($urandom_range(99) < 10) rq.id = ID_ALL_ONES;
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one word per handshake, driven on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(request_t rq, bit typed, outcome_t want);
    outcome_t predicted;
    @(negedge clk);
    in_operation     = rq.op;
    in_device_is_tag = rq.tag;
    in_father_addr   = rq.father;
    in_node_id       = rq.id;
    in_short_addr    = rq.saddr;
    in_valid         = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: update the shadow table in acceptance order
    predicted = allocate_step(rq);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
    // random gaps between words, except in the steady window
    while (!steady_window() && $urandom_range(99) < 32) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  function automatic outcome_t hit(logic [15:0] sa, logic [63:0] id);
    return {1'b1, sa, id};
  endfunction

  task automatic add_row(logic [2:0] op, logic tag, logic [15:0] father, logic [63:0] id,
                         logic [15:0] saddr, bit typed, outcome_t want);
    directed_row_t row;
    row.rq    = {op, tag, father, id, saddr};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready, with one long hold to back the block up
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = steady_window() || ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("result %0d: %s got %h want %h", results_seen, field, got, want);
    mismatches++;
  endtask

  // Results are checked in order against the oldest pending expectation.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 64'({out_success, out_short_addr_out}), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_success !== want.ok)
          report_mismatch("success", 64'(out_success), 64'(want.ok));
        if (out_short_addr_out !== want.sa)
          report_mismatch("short_addr_out", 64'(out_short_addr_out), 64'(want.sa));
        if (out_node_id_out !== want.id)
          report_mismatch("node_id_out", out_node_id_out, want.id);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_ADD;
    in_device_is_tag = 1'b0;
    in_father_addr   = '0;
    in_node_id       = '0;
    in_short_addr    = '0;
    words_sent       = 0;
    results_seen     = 0;
    mismatches       = 0;
    for (int k = 0; k < TABLE_SLOTS; k++) claim_slot(k, EMPTY_ADDR, ID_ALL_ONES);
    id_pool[0] = '0;
    id_pool[1] = ID_ALL_ONES;
    for (int k = 2; k < 8; k++) id_pool[k] = {$urandom, $urandom};

    // Directed table. Typed answers follow from an empty table after reset.
    // empty table: searches skip free slots, even for an all-ones id
    add_row(OP_FIND,   0, 16'h0000, 64'd0,        16'h0000, 1, NO_HIT);
    add_row(OP_FIND,   0, 16'h0000, ID_ALL_ONES,  16'h0000, 1, NO_HIT);
    add_row(OP_LONG,   0, 16'h0000, 64'd0,        16'h0001, 1, NO_HIT);
    // two routers, then one tag under each
    add_row(OP_ADD,    0, 16'h0000, 64'd0,        16'h0000, 1, hit(16'h0001, 64'd0));
    add_row(OP_ADD,    0, 16'hFFFF, ID_ALL_ONES,  16'hFFFF, 1, hit(16'h0101, 64'd0));
    add_row(OP_ADD,    1, 16'h0001, 64'h0123_4567_89AB_CDEF, 16'h0000, 1,
            hit(16'h0002, 64'd0));
    add_row(OP_ADD,    1, 16'h0101, ID_ALL_ONES,  16'h0000, 1, hit(16'h0102, 64'd0));
    // father that is no router address: all ones, then a tag's address
    add_row(OP_ADD,    1, 16'hFFFF, 64'd5,        16'h0000, 1, NO_HIT);
    add_row(OP_ADD,    1, 16'h0002, 64'd6,        16'h0000, 1, NO_HIT);
    // lookups of what was just placed
    add_row(OP_LONG,   0, 16'h0000, 64'd0,        16'h0002, 1,
            {1'b0 | 1'b1, EMPTY_ADDR, 64'h0123_4567_89AB_CDEF});
    add_row(OP_LONG,   1, 16'h0000, 64'd0,        16'h0101, 1, {1'b1, EMPTY_ADDR, ID_ALL_ONES});
    add_row(OP_JOIN,   1, 16'h0001, 64'h0123_4567_89AB_CDEF, 16'h0000, 1,
            hit(16'h0002, 64'd0));
    add_row(OP_JOIN,   0, 16'h0000, ID_ALL_ONES,  16'h0000, 1, hit(16'h0101, 64'd0));
    add_row(OP_FIND,   0, 16'h0000, ID_ALL_ONES,  16'h0000, 1, hit(16'h0101, 64'd0));
    add_row(OP_FIND,   1, 16'hFFFF, 64'd0,        16'hFFFF, 1, hit(16'h0001, 64'd0));
    // delete with the row byte out of range twice, then a real delete twice
    add_row(OP_DELETE, 0, 16'h0000, 64'd0,        16'hFF01, 1, NO_HIT);
    add_row(OP_DELETE, 0, 16'h0000, 64'd0,        16'h1001, 1, NO_HIT);
    add_row(OP_DELETE, 0, 16'h0000, 64'd0,        16'h0002, 1, {1'b1, EMPTY_ADDR, 64'd0});
    add_row(OP_DELETE, 0, 16'h0000, 64'd0,        16'h0002, 1, NO_HIT);
    // spare codes, the first with every field at its top
    add_row(OP_SPARE5, 1, 16'hFFFF, ID_ALL_ONES,  16'hFFFF, 1, NO_HIT);
    add_row(OP_SPARE6, 1, 16'h0001, 64'd0,        16'h0001, 1, NO_HIT);
    add_row(OP_SPARE7, 0, 16'h0101, ID_ALL_ONES,  16'h0101, 1, NO_HIT);
    // slot reuse, join miss in a row, router removal and refill
    add_row(OP_ADD,    1, 16'h0001, 64'h0123_4567_89AB_CDEF, 16'h0000, 0, NO_HIT);
    add_row(OP_JOIN,   1, 16'h0101, 64'd0,        16'h0000, 0, NO_HIT);
    add_row(OP_DELETE, 0, 16'h0000, 64'd0,        16'h0001, 0, NO_HIT);
    add_row(OP_ADD,    0, 16'h0000, 64'hFEDC_BA98_7654_3210, 16'h0000, 0, NO_HIT);
    add_row(OP_FIND,   0, 16'h0000, 64'h0123_4567_89AB_CDEF, 16'h0000, 0, NO_HIT);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

    // random traffic in alternating fill and drain blocks
    for (int n = 0; n < RANDOM_WORDS; n++)
      send_word(random_request(((n / 250) % 2) == 1), 1'b0, NO_HIT);

    @(negedge clk);
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("network_address_allocation_table: match");
    end else begin
      $display("network_address_allocation_table: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/naat_pkg.sv
hw/rtl/network_address_allocation_table.sv
sim/tb_network_address_allocation_table.sv
